// File: src/drf_pkg.sv
// ----------------------------------------------------------------------------
// drf_pkg
// Shared types and constants for the diagnostic response frame receiver.
// ----------------------------------------------------------------------------
package drf_pkg;

  // Frame layout: format, target, source, service id, data..., checksum
  localparam logic [6:0] POS_FORMAT = 7'd0;
  localparam logic [6:0] POS_TARGET = 7'd1;
  localparam logic [6:0] POS_SOURCE = 7'd2;
  localparam logic [6:0] POS_SID    = 7'd3;
  localparam logic [6:0] POS_DATA   = 7'd4;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_CSUM = 2'd1,
    ST_ZLEN = 2'd2
  } drf_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } drf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // consume the presented input item
    logic emit;       // load the next payload byte of the run into the output
  } drf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic good_end;   // presented byte is a matching checksum
    logic run_last;   // next payload byte to emit is the final one
    logic out_free;   // output register is empty or being transferred
  } drf_sts_t;

endpackage

// File: src/drf_ctrl.sv
// ----------------------------------------------------------------------------
// drf_ctrl
// Controller: accepts line bytes while idle, sequences the payload run.
// ----------------------------------------------------------------------------
module drf_ctrl
  import drf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  drf_sts_t   sts,
  output drf_cmd_t   cmd
);

  drf_state_t state;
  drf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (byte_valid && sts.out_free && sts.good_end) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.out_free && sts.run_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    byte_stall = 1'b1;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        byte_stall = !sts.out_free;
        cmd.take   = byte_valid && sts.out_free;
      end
      S_RUN: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        byte_stall = 1'b1;
      end
    endcase
  end

  // Never take input while a run is being sent
  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (byte_stall && !cmd.take))
    else $error("input taken during payload run");

  // A matching checksum starts a run
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && sts.good_end) |=> (state == S_RUN))
    else $error("run did not start after good checksum");

  // Take and emit are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && cmd.emit))
    else $error("take and emit in the same cycle");

endmodule

// File: src/drf_datapath.sv
// ----------------------------------------------------------------------------
// drf_datapath
// Frame parser registers, running sum, data byte store and result register.
// ----------------------------------------------------------------------------
module drf_datapath
  import drf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  drf_cmd_t    cmd,
  output drf_sts_t    sts,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [7:0]  payload_byte,
  output logic [5:0]  byte_index,
  output logic [5:0]  payload_length,
  output logic [7:0]  target_address,
  output logic [7:0]  source_address,
  output logic        last
);

  // Parser state
  logic [6:0] position;
  logic [5:0] frame_len;
  logic [7:0] target_hold;
  logic [7:0] source_hold;
  logic [7:0] sid_hold;
  logic [7:0] running_sum;
  logic [5:0] run_cnt;

  // Data byte store
  logic [7:0] data_mem [64];
  logic [7:0] mem_q;

  // Result register
  logic        out_valid;
  drf_status_t out_status;
  logic [7:0]  out_pb;
  logic        out_sel_mem;
  logic [5:0]  out_idx;
  logic [5:0]  out_len;
  logic [7:0]  out_tgt;
  logic [7:0]  out_src;
  logic        out_last;

  logic       byte_in;
  logic       at_csum;
  logic       csum_ok;
  logic       zero_len;
  logic       load_single;
  logic [6:0] csum_pos;
  logic [5:0] wr_addr;
  logic [5:0] rd_addr;

  assign byte_in  = cmd.take && (kind == KIND_BYTE);
  assign csum_pos = POS_SID + {1'b0, frame_len};
  assign at_csum  = (position > POS_SID) && (position >= csum_pos);
  assign csum_ok  = (rx_byte == running_sum);
  assign zero_len = (position == POS_FORMAT) && (rx_byte[5:0] == 6'd0);
  assign wr_addr  = 6'(position - POS_DATA);
  assign rd_addr  = run_cnt - 6'd1;

  assign sts.good_end = (kind == KIND_BYTE) && at_csum && csum_ok;
  assign sts.run_last = (run_cnt == (frame_len - 6'd1));
  assign sts.out_free = !out_valid || !result_stall;

  assign load_single = byte_in && (zero_len || (at_csum && !csum_ok));

  // Parser: advance position and sum, restart after each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      running_sum <= '0;
      frame_len   <= '0;
      target_hold <= '0;
      source_hold <= '0;
      sid_hold    <= '0;
    end else if (cmd.take) begin
      if (kind == KIND_RESTART) begin
        position    <= '0;
        running_sum <= '0;
      end else if (zero_len || at_csum) begin
        if (position == POS_FORMAT) begin
          frame_len <= rx_byte[5:0];
        end
        position    <= '0;
        running_sum <= '0;
      end else begin
        case (position)
          POS_FORMAT: frame_len   <= rx_byte[5:0];
          POS_TARGET: target_hold <= rx_byte;
          POS_SOURCE: source_hold <= rx_byte;
          POS_SID:    sid_hold    <= rx_byte;
          default: ;
        endcase
        running_sum <= running_sum + rx_byte;
        position    <= position + 7'd1;
      end
    end
  end

  // Run counter: clear on every checksum byte, step on every emitted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (byte_in && at_csum) begin
      run_cnt <= '0;
    end else if (cmd.emit) begin
      run_cnt <= run_cnt + 6'd1;
    end
  end

  // Store write: data bytes only
  always_ff @(posedge clk) begin
    if (byte_in && !zero_len && !at_csum && (position >= POS_DATA)) begin
      data_mem[wr_addr] <= rx_byte;
    end
  end

  // Store read: registered, updated only when a run byte is loaded
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mem_q <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_single || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!result_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status  <= ST_GOOD;
      out_pb      <= sid_hold;
      out_sel_mem <= (run_cnt != 6'd0);
      out_idx     <= run_cnt;
      out_len     <= frame_len;
      out_tgt     <= target_hold;
      out_src     <= source_hold;
      out_last    <= sts.run_last;
    end else if (load_single) begin
      out_pb      <= '0;
      out_sel_mem <= 1'b0;
      out_idx     <= '0;
      out_last    <= 1'b1;
      if (zero_len) begin
        out_status <= ST_ZLEN;
        out_len    <= '0;
        out_tgt    <= '0;
        out_src    <= '0;
      end else begin
        out_status <= ST_CSUM;
        out_len    <= frame_len;
        out_tgt    <= target_hold;
        out_src    <= source_hold;
      end
    end
  end

  assign result_valid   = out_valid;
  assign status         = out_status;
  assign payload_byte   = out_sel_mem ? mem_q : out_pb;
  assign byte_index     = out_idx;
  assign payload_length = out_len;
  assign target_address = out_tgt;
  assign source_address = out_src;
  assign last           = out_last;

  // Error results always close their run
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_GOOD)) |-> out_last)
    else $error("error result without last");

  // Payload indices stay inside the frame length
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_GOOD)) |-> (out_idx < out_len))
    else $error("payload index beyond length");

  // Parser position never runs past the longest frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= (POS_SID + 7'd63))
    else $error("parser position out of range");

endmodule

// File: src/diag_response_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// diag_response_frame_receiver_unit
// K-line diagnostic frame receiver with additive checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall): one transfer per received line
//   byte (kind = 0) or a parser restart (kind = 1). A frame is format,
//   target, source, service id, data bytes and checksum; the low six format
//   bits give the payload length L.
//   Output channel (result_valid / result_stall): on a matching checksum the
//   payload (service id, then data) leaves as L transfers, the final one with
//   last set. A mismatch gives one checksum-error transfer, a zero length
//   format one malformed transfer; the parser restarts after every frame.
//   Timing: an error or malformed result is registered and visible the cycle
//   after the byte that causes it; the first payload byte of a run is loaded
//   once the controller has entered its run state and is then registered in
//   the result register. A run sends one payload byte per cycle while the
//   receiver does not stall; a frame end holds the input until the run is
//   done, while the stored data is read from the 64-entry store, one read
//   port, one entry per cycle. Other bytes are held only while a result waits.
//   Reset clears the parser and empties the result register; the data store
//   is not cleared. When the receiver stalls a result, the result register
//   holds it and the input is stalled too, so nothing is dropped.
// ----------------------------------------------------------------------------
module diag_response_frame_receiver_unit
  import drf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input byte channel
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] status,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_index,
  output logic [5:0] payload_length,
  output logic [7:0] target_address,
  output logic [7:0] source_address,
  output logic       last
);

  drf_cmd_t cmd;
  drf_sts_t sts;

  // Sequencer: take bytes while idle, walk the payload after a good checksum
  drf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Parser registers, running sum, data store and result register
  drf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (kind),
    .rx_byte        (rx_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .payload_length (payload_length),
    .target_address (target_address),
    .source_address (source_address),
    .last           (last)
  );

endmodule

// File: dv/diag_response_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diag_response_frame_receiver_unit_tb
// Feeds K-line bytes and parser restarts into the frame receiver. It checks
// every payload, checksum-error and zero-length transfer against a predictor
// that runs next to the block. The run covers directed corner frames, then
// random frames under three idle and stall mixes.
// ----------------------------------------------------------------------------
module diag_response_frame_receiver_unit_tb;
  import drf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          TAIL_CYCLES = 100;   // longer than one 63-byte run
  localparam int          PRINT_CAP   = 40;

  // One transfer on the result channel
  typedef struct {
    drf_status_t status;
    logic [7:0]  pbyte;
    logic [5:0]  idx;
    logic [5:0]  plen;
    logic [7:0]  tgt;
    logic [7:0]  src;
    logic        last;
  } payload_rec_t;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  logic       kind;
  logic [7:0] rx_byte;
  logic       result_valid;
  logic       result_stall;
  logic [1:0] status;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic [5:0] payload_length;
  logic [7:0] target_address;
  logic [7:0] source_address;
  logic       last;

  diag_response_frame_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .kind          (kind),
    .rx_byte       (rx_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .payload_length(payload_length),
    .target_address(target_address),
    .source_address(source_address),
    .last          (last)
  );

  // Predicted parser state
  logic [6:0] rx_pos;
  logic [7:0] fmt_q;
  logic [7:0] tgt_q;
  logic [7:0] src_q;
  logic [7:0] sid_q;
  logic [7:0] csum_acc;
  logic [7:0] data_mem [64];

  payload_rec_t pending_payload [$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          error_count;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // Clock, watchdog and receiver stall
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[diag_response_frame_receiver_unit] ERROR");
        $finish;
      end
    end
  end

  // Redraw the stall every cycle so gaps land on every phase of a run
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: advance the parser by one accepted input item and queue the
  // transfers it causes.
  // --------------------------------------------------------------------------
  function automatic payload_rec_t make_rec(drf_status_t st, logic [7:0] pb, logic [5:0] ix,
                                            logic [5:0] ln, logic [7:0] tg, logic [7:0] sr,
                                            logic lst);
    payload_rec_t r;
    r.status = st;
    r.pbyte  = pb;
    r.idx    = ix;
    r.plen   = ln;
    r.tgt    = tg;
    r.src    = sr;
    r.last   = lst;
    return r;
  endfunction

  task automatic decode_frame_byte(input logic k, input logic [7:0] b);
    logic [5:0] len;
    int         i;
    len = fmt_q[5:0];
    if (k == KIND_RESTART) begin
      rx_pos   = POS_FORMAT;
      csum_acc = 8'd0;
      return;
    end
    if (rx_pos == POS_FORMAT) begin
      fmt_q = b;
      // Zero length format: flag it and restart with cleared header fields
      if (b[5:0] == 6'd0) begin
        pending_payload.push_back(make_rec(ST_ZLEN, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0, 1'b1));
        rx_pos   = POS_FORMAT;
        csum_acc = 8'd0;
        return;
      end
    end else if (rx_pos == POS_TARGET) begin
      tgt_q = b;
    end else if (rx_pos == POS_SOURCE) begin
      src_q = b;
    end else if (rx_pos == POS_SID) begin
      sid_q = b;
    end else if (rx_pos >= POS_SID + 7'(len)) begin
      // Checksum byte: the whole payload on a match, one error otherwise
      if (b == csum_acc) begin
        for (i = 0; i < len; i++) begin
          pending_payload.push_back(make_rec(ST_GOOD, (i == 0) ? sid_q : data_mem[i - 1],
                                             6'(i), len, tgt_q, src_q, (i + 1 == len)));
        end
      end else begin
        pending_payload.push_back(make_rec(ST_CSUM, 8'd0, 6'd0, len, tgt_q, src_q, 1'b1));
      end
      rx_pos   = POS_FORMAT;
      csum_acc = 8'd0;
      return;
    end else begin
      data_mem[6'(rx_pos - POS_DATA)] = b;
    end
    csum_acc = csum_acc + b;
    rx_pos   = rx_pos + 7'd1;
  endtask

  // --------------------------------------------------------------------------
  // Input side: one transfer per call, called at a rising edge
  // --------------------------------------------------------------------------
  task automatic push_line_byte(input logic k, input logic [7:0] b);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_valid <= 1'b1;
    kind       <= k;
    rx_byte    <= b;
    // Sample the stall mid-cycle; it is settled long before the next edge
    do begin
      @(negedge clk);
      taken = !byte_stall;
      @(posedge clk);
    end while (!taken);
    decode_frame_byte(k, b);
    items_sent++;
  endtask

  // Send one frame of payload length plen: format, target, source, service
  // id, plen-1 data bytes and the checksum. Cut it short with a restart after
  // cut_at bytes when cut_at is not negative; spoil the checksum on bad_sum.
  task automatic send_frame(input int plen, input logic [1:0] hdr_bits, input bit bad_sum,
                            input int cut_at);
    logic [7:0] frame [67];
    logic [7:0] sum;
    int         n;
    int         i;
    n        = plen + 3;
    frame[0] = {hdr_bits, 6'(plen)};
    for (i = 1; i < n; i++) frame[i] = 8'($urandom_range(255));
    sum = 8'd0;
    for (i = 0; i < n; i++) sum = sum + frame[i];
    frame[n] = bad_sum ? (sum ^ 8'($urandom_range(255, 1))) : sum;
    for (i = 0; i <= n; i++) begin
      if (i == cut_at) begin
        push_line_byte(KIND_RESTART, 8'($urandom_range(255)));
        return;
      end
      push_line_byte(KIND_BYTE, frame[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: compare each transfer with the oldest expectation
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  initial begin
    payload_rec_t want;
    forever begin
      @(negedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_payload.size() == 0) begin
          flag_mismatch($sformatf("unexpected transfer status=%0d byte=%02h", status,
                                  payload_byte));
        end else begin
          want = pending_payload.pop_front();
          if (status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
          if (payload_byte !== want.pbyte)
            flag_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte, want.pbyte));
          if (byte_index !== want.idx)
            flag_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.idx));
          if (payload_length !== want.plen)
            flag_mismatch($sformatf("payload_length %0d, want %0d", payload_length,
                                    want.plen));
          if (target_address !== want.tgt)
            flag_mismatch($sformatf("target_address %02h, want %02h", target_address,
                                    want.tgt));
          if (source_address !== want.src)
            flag_mismatch($sformatf("source_address %02h, want %02h", source_address,
                                    want.src));
          if (last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero length formats, with and without header mode bits
  task automatic check_zero_length_format();
    push_line_byte(KIND_BYTE, 8'h00);
    push_line_byte(KIND_BYTE, 8'hC0);
    push_line_byte(KIND_BYTE, 8'h40);
  endtask

  // Single-byte payload at the byte extremes, then a two-byte payload with
  // both mode bits set and a checksum that wraps
  task automatic check_minimal_frames();
    push_line_byte(KIND_BYTE, 8'h01);
    push_line_byte(KIND_BYTE, 8'hFF);
    push_line_byte(KIND_BYTE, 8'h00);
    push_line_byte(KIND_BYTE, 8'hFF);
    push_line_byte(KIND_BYTE, 8'hFF);
    push_line_byte(KIND_BYTE, 8'hC2);
    push_line_byte(KIND_BYTE, 8'h00);
    push_line_byte(KIND_BYTE, 8'hFF);
    push_line_byte(KIND_BYTE, 8'h00);
    push_line_byte(KIND_BYTE, 8'h00);
    push_line_byte(KIND_BYTE, 8'hC1);
  endtask

  // Checksum mismatch: the true sum is 8'h9D
  task automatic check_checksum_mismatch();
    push_line_byte(KIND_BYTE, 8'h01);
    push_line_byte(KIND_BYTE, 8'h12);
    push_line_byte(KIND_BYTE, 8'h34);
    push_line_byte(KIND_BYTE, 8'h56);
    push_line_byte(KIND_BYTE, 8'h00);
  endtask

  // Restart while idle, restart mid-frame, then a clean frame to prove the
  // parser picked up again from the format byte
  task automatic check_restart_handling();
    push_line_byte(KIND_RESTART, 8'hFF);
    send_frame(3, 2'b10, 1'b0, 2);
    send_frame(2, 2'b01, 1'b0, -1);
  endtask

  // Mostly well-formed frames of random content; the rest are spoiled
  // checksums, frames cut by a restart, and bursts of line noise.
  task automatic run_random_frames(input int idle_pct, input int stall_pct, input int n_items);
    int  stop_at;
    int  pick;
    int  plen;
    int  i;
    int  burst;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + n_items;
    // Open each mix with one full-length frame
    send_frame(63, 2'($urandom_range(3)), 1'b0, -1);
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 85) plen = $urandom_range(8, 1);
      else if (pick < 96) plen = $urandom_range(30, 9);
      else plen = $urandom_range(63, 31);
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame(plen, 2'($urandom_range(3)), 1'b0, -1);
      end else if (pick < 87) begin
        send_frame(plen, 2'($urandom_range(3)), 1'b1, -1);
      end else if (pick < 94) begin
        send_frame(plen, 2'($urandom_range(3)), 1'b0, $urandom_range(plen + 4, 0));
      end else begin
        burst = $urandom_range(4, 1);
        for (i = 0; i < burst; i++)
          push_line_byte(($urandom_range(3) == 0) ? KIND_RESTART : KIND_BYTE,
                         8'($urandom_range(255)));
        push_line_byte(KIND_RESTART, 8'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    byte_valid     = 1'b0;
    kind           = KIND_BYTE;
    rx_byte        = 8'd0;
    send_idle_pct  = 24;
    recv_stall_pct = 68;
    items_sent     = 0;
    error_count    = 0;
    rx_pos         = POS_FORMAT;
    fmt_q          = 8'd0;
    tgt_q          = 8'd0;
    src_q          = 8'd0;
    sid_q          = 8'd0;
    csum_acc       = 8'd0;
    foreach (data_mem[i]) data_mem[i] = 8'd0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_zero_length_format();
    check_minimal_frames();
    check_checksum_mismatch();
    check_restart_handling();

    run_random_frames(24, 68, 140);
    run_random_frames(68, 24, 140);
    run_random_frames(0, 0, 140);

    // Drain, then give a late or extra transfer time to show up
    byte_valid <= 1'b0;
    while (pending_payload.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_payload.size() == 0) begin
      $display("[diag_response_frame_receiver_unit] OK");
    end else begin
      $display("[diag_response_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule
